@@ rtl/core/atmcc_pkg.sv @@
// Shared types and constants for the access timed master cycle counter.
// Used by every module in rtl/core; no dependencies.
package atmcc_pkg;

  localparam int LINE_CYCLES     = 1364;
  localparam int LINES_PER_FRAME = 262;

  localparam int COUNT_W    = 32;
  localparam int REM_W      = $clog2(LINE_CYCLES);
  localparam int LINE_W     = $clog2(LINES_PER_FRAME);
  localparam int POS_W      = 9;
  localparam int ADD_W      = 12;
  localparam int MAX_ADD    = 255 * 12;
  localparam int VAL_W      = $clog2(LINE_CYCLES + MAX_ADD);
  localparam int NORM_STEPS = (LINE_CYCLES - 1 + MAX_ADD) / LINE_CYCLES;

  // 2^32 expressed as whole lines plus a remainder, for counter wrap
  localparam longint unsigned COUNT_SPAN = 64'd1 << COUNT_W;
  localparam logic [REM_W-1:0]  WRAP_REM   = REM_W'(COUNT_SPAN % LINE_CYCLES);
  localparam logic [LINE_W-1:0] WRAP_LINES =
    LINE_W'((COUNT_SPAN / LINE_CYCLES) % LINES_PER_FRAME);

  localparam logic [1:0] OP_ACCESS   = 2'd0;
  localparam logic [1:0] OP_INTERNAL = 2'd1;
  localparam logic [1:0] OP_COND     = 2'd2;
  localparam logic [1:0] OP_RAW      = 2'd3;

  localparam logic [3:0] SPEED_FAST  = 4'd6;
  localparam logic [3:0] SPEED_SLOW  = 4'd8;
  localparam logic [3:0] SPEED_XSLOW = 4'd12;

  localparam logic [7:0]  BANK_SYS_END    = 8'h3f;
  localparam logic [7:0]  BANK_WRAM_END   = 8'h7f;
  localparam logic [7:0]  BANK_MIRROR_END = 8'hbf;
  localparam logic [15:0] OFS_LOWRAM_END  = 16'h1fff;
  localparam logic [15:0] OFS_PPU_END     = 16'h3fff;
  localparam logic [15:0] OFS_JOY_END     = 16'h41ff;
  localparam logic [15:0] OFS_CPUIO_END   = 16'h5fff;
  localparam logic [15:0] OFS_EXP_END     = 16'h7fff;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  count;
    logic [23:0] access_address;
    logic [2:0]  condition_flags;
    logic        bank_crossed;
    logic [7:0]  direct_low;
    logic        index_short;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] master_total;
    logic [POS_W-1:0]   scanline;
    logic [POS_W-1:0]   dot;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [REM_W-1:0]   rem;
    logic [LINE_W-1:0]  line;
  } scan_t;

endpackage

@@ rtl/core/atmcc_cycle_calc.sv @@
// Master cycles added by one bus event: speed map decode and count scaling.
// Depends on atmcc_pkg.
module atmcc_cycle_calc (
  input  atmcc_pkg::item_t               item,
  input  logic                           fast_rom,
  output logic [atmcc_pkg::ADD_W-1:0]    added
);
  import atmcc_pkg::*;

  logic [7:0]  bank;
  logic [15:0] offset;
  logic [3:0]  rom_speed;
  logic [3:0]  speed;
  logic [1:0]  extra;
  logic [8:0]  cpu_cycles;

  assign bank      = item.access_address[23:16];
  assign offset    = item.access_address[15:0];
  assign rom_speed = fast_rom ? SPEED_FAST : SPEED_SLOW;

  always_comb begin
    if (bank > BANK_MIRROR_END) begin
      speed = rom_speed;
    end else if (bank > BANK_SYS_END && bank <= BANK_WRAM_END) begin
      speed = SPEED_SLOW;
    end else if (offset <= OFS_LOWRAM_END) begin
      speed = SPEED_SLOW;
    end else if (offset <= OFS_PPU_END) begin
      speed = SPEED_FAST;
    end else if (offset <= OFS_JOY_END) begin
      speed = SPEED_XSLOW;
    end else if (offset <= OFS_CPUIO_END) begin
      speed = SPEED_FAST;
    end else if (offset <= OFS_EXP_END) begin
      speed = SPEED_SLOW;
    end else begin
      speed = (bank <= BANK_SYS_END) ? SPEED_SLOW : rom_speed;
    end
  end

  assign extra = 2'(item.condition_flags[0] && item.bank_crossed)
               + 2'(item.condition_flags[1] && (item.direct_low != 8'd0))
               + 2'(item.condition_flags[2] && (item.bank_crossed || !item.index_short));
  assign cpu_cycles = {1'b0, item.count} + 9'(extra);

  always_comb begin
    unique case (item.operation)
      OP_ACCESS:   added = ADD_W'(item.count) * ADD_W'(speed);
      OP_INTERNAL: added = ADD_W'(item.count) * ADD_W'(SPEED_FAST);
      OP_COND:     added = ADD_W'(cpu_cycles) * ADD_W'(SPEED_FAST);
      OP_RAW:      added = ADD_W'(item.count);
      default:     added = '0;
    endcase
  end

endmodule

@@ rtl/core/atmcc_scan_next.sv @@
// Next master count and scan position (line, cycle within line).
// Handles 32-bit wrap by removing the line/remainder share of 2^32. Depends on atmcc_pkg.
module atmcc_scan_next (
  input  atmcc_pkg::scan_t            cur,
  input  logic [atmcc_pkg::ADD_W-1:0] added,
  output atmcc_pkg::scan_t            nxt
);
  import atmcc_pkg::*;

  logic [COUNT_W:0]  sum;
  logic [VAL_W-1:0]  val;
  logic              borrow;
  logic [LINE_W:0]   dec;
  logic [LINE_W-1:0] line;

  always_comb begin
    sum    = {1'b0, cur.count} + (COUNT_W + 1)'(added);
    val    = VAL_W'(cur.rem) + VAL_W'(added);
    borrow = 1'b0;
    dec    = '0;
    if (sum[COUNT_W]) begin
      if (val >= VAL_W'(WRAP_REM)) begin
        val = val - VAL_W'(WRAP_REM);
      end else begin
        val    = val + VAL_W'(LINE_CYCLES) - VAL_W'(WRAP_REM);
        borrow = 1'b1;
      end
      dec = (LINE_W + 1)'(WRAP_LINES) + (LINE_W + 1)'(borrow);
    end
    if ((LINE_W + 1)'(cur.line) >= dec) begin
      line = LINE_W'((LINE_W + 1)'(cur.line) - dec);
    end else begin
      line = LINE_W'((LINE_W + 1)'(cur.line) + (LINE_W + 1)'(LINES_PER_FRAME) - dec);
    end
    for (int i = 0; i < NORM_STEPS; i++) begin
      if (val >= VAL_W'(LINE_CYCLES)) begin
        val  = val - VAL_W'(LINE_CYCLES);
        line = (line == LINE_W'(LINES_PER_FRAME - 1)) ? '0 : line + 1'b1;
      end
    end
    nxt.count = sum[COUNT_W-1:0];
    nxt.rem   = REM_W'(val);
    nxt.line  = line;
  end

endmodule

@@ rtl/core/access_timed_master_cycle_counter.sv @@
// Top level of the access timed master cycle counter.
// Depends on atmcc_pkg, atmcc_cycle_calc and atmcc_scan_next.
//
// Usage:
//   item channel (item_valid / item_stall / item): one bus event per beat.
//   result channel (result_valid / result_stall / result): one beat per item
//   with the new master count, scanline and dot.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes fast_rom; always
//   ready. Write it only while no item is in flight.
// Path: an accepted item is held in the input register, then its result is
// written to the result register; a result stall can hold it in between.
// Throughput: one item per cycle while result_stall is not holding; the
// speed decode, scaling multiply and scan position update all fit between the input and result registers.
// Stall: while result_stall holds, the result register and one item in the
// input register are kept; item_stall rises only when both are full.
// Reset (rst, synchronous): count, scan position and fast_rom clear to zero,
// both channels go empty.
module access_timed_master_cycle_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  atmcc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output atmcc_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import atmcc_pkg::*;

  logic              fast_rom;
  logic              stage_valid;
  item_t             stage_item;
  scan_t             scan;
  scan_t             scan_next;
  logic [ADD_W-1:0]  added;
  logic              stage_adv;

  assign cfg_ready  = 1'b1;
  assign stage_adv  = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && result_valid && result_stall;

  atmcc_cycle_calc u_cycle_calc (
    .item     (stage_item),
    .fast_rom (fast_rom),
    .added    (added)
  );

  atmcc_scan_next u_scan_next (
    .cur   (scan),
    .added (added),
    .nxt   (scan_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_rom     <= 1'b0;
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      scan         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fast_rom <= cfg_data;
      end
      if (!item_stall) begin
        stage_valid <= item_valid;
      end
      if (stage_adv) begin
        scan         <= scan_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
    if (stage_adv) begin
      result.master_total <= scan_next.count;
      result.scanline     <= POS_W'(scan_next.line);
      result.dot          <= POS_W'(scan_next.rem >> 2);
    end
  end

  // while result_valid is high, the result register mirrors the running count
  a_total_tracks: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.master_total == scan.count)
    else $error("result master_total differs from running count");

  a_dot_tracks: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.dot == POS_W'(scan.rem >> 2))
    else $error("result dot differs from line remainder");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (scan.rem < REM_W'(LINE_CYCLES)) && (scan.line < LINE_W'(LINES_PER_FRAME)))
    else $error("scan position out of range");

  a_item_lands: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> stage_valid)
    else $error("accepted beat lost from input register");

endmodule
